// ===== rtl/spc_pkg.sv =====
package spc_pkg;

    // Mode codes of the action field
    localparam logic [1:0] ACT_BOX_BOX    = 2'd0;
    localparam logic [1:0] ACT_BOX_CIRCLE = 2'd1;
    localparam logic [1:0] ACT_CIRCLE_BOX = 2'd2;
    localparam logic [1:0] ACT_CIRC_CIRC  = 2'd3;

    // Step counts of the shared serial units
    localparam int MUL_STEPS = 37;
    localparam int RT_STEPS  = 38;
    localparam int DIV_STEPS = 76;

    localparam int QUEUE_DEPTH = 4;

    // One classified transaction as it waits between front and back
    typedef struct packed {
        logic        is_box;
        logic        bb_hit;
        logic [31:0] bb_px;
        logic [31:0] bb_py;
        logic        cc;
        logic        negate;
        logic [36:0] ax;
        logic [36:0] ay;
        logic [35:0] mlx;
        logic [35:0] mly;
        logic        sx;
        logic        sy;
        logic [31:0] rad;
    } spc_job_t;

    // Give a magnitude its sign and clamp it to the signed 32 bit range
    function automatic logic [31:0] spc_sat(input logic [33:0] q, input logic neg);
        logic [34:0] qe;
        logic [34:0] nq;
        begin
            qe = {1'b0, q};
            nq = ~qe + 35'd1;
            if (!neg)
            begin
                spc_sat = (qe > 35'h07FFFFFFF) ? 32'h7FFFFFFF : qe[31:0];
            end
            else
            begin
                spc_sat = (qe > 35'h080000000) ? 32'h80000000 : nq[31:0];
            end
        end
    endfunction

endpackage

// ===== rtl/spc_front.sv =====
module spc_front (
    input  logic [1:0]         action,
    input  logic [31:0]        first_x,
    input  logic [31:0]        first_y,
    input  logic [30:0]        first_width,
    input  logic [30:0]        first_height,
    input  logic [31:0]        second_x,
    input  logic [31:0]        second_y,
    input  logic [30:0]        second_width,
    input  logic [30:0]        second_height,
    output spc_pkg::spc_job_t  job
);

    logic signed [37:0] x1, y1, w1, h1, x2, y2, w2, h2;
    logic signed [37:0] dx, dy, adx, ady, pen;
    logic               bb_ok;
    logic signed [37:0] bx, by, bw, bh, cx, cy, cr;
    logic signed [37:0] lx, ly, kx, ky, ex, ey, aex, aey, alx, aly;
    logic signed [37:0] rsum;
    logic               is_cc;

    // Extend all fields to a common signed width
    assign x1 = {{6{first_x[31]}}, first_x};
    assign y1 = {{6{first_y[31]}}, first_y};
    assign w1 = {7'b0, first_width};
    assign h1 = {7'b0, first_height};
    assign x2 = {{6{second_x[31]}}, second_x};
    assign y2 = {{6{second_y[31]}}, second_y};
    assign w2 = {7'b0, second_width};
    assign h2 = {7'b0, second_height};

    // Box against box: inclusive overlap and push along the dominant axis
    always_comb
    begin
        bb_ok = (x1 + w1 >= x2) && (x2 + w2 >= x1) && (y1 + h1 >= y2) && (y2 + h2 >= y1);
        dx    = 2 * x1 + w1 - 2 * x2 - w2;
        dy    = 2 * y1 + h1 - 2 * y2 - h2;
        adx   = dx[37] ? -dx : dx;
        ady   = dy[37] ? -dy : dy;
        if (adx > ady)
        begin
            pen = (w1 + w2 - adx) >>> 1;
        end
        else
        begin
            pen = (h1 + h2 - ady) >>> 1;
        end
    end

    // Select which shape is the box and which the circle
    always_comb
    begin
        is_cc = (action == spc_pkg::ACT_CIRC_CIRC);
        if (action == spc_pkg::ACT_CIRCLE_BOX)
        begin
            bx = x2; by = y2; bw = w2; bh = h2;
            cx = x1; cy = y1; cr = w1;
        end
        else
        begin
            bx = x1; by = y1; bw = w1; bh = h1;
            cx = x2; cy = y2; cr = w2;
        end
        rsum = w1 + w2;
        if (is_cc)
        begin
            lx = (x1 + w1) - (x2 + w2);
            ly = (y1 + w1) - (y2 + w2);
        end
        else
        begin
            lx = 2 * cx + 2 * cr - 2 * bx - bw;
            ly = 2 * cy + 2 * cr - 2 * by - bh;
        end
        // Clamp to the nearest box point, in doubled units
        kx  = (lx < -bw) ? -bw : ((lx > bw) ? bw : lx);
        ky  = (ly < -bh) ? -bh : ((ly > bh) ? bh : ly);
        alx = lx[37] ? -lx : lx;
        aly = ly[37] ? -ly : ly;
        ex  = kx - lx;
        ey  = ky - ly;
        aex = ex[37] ? -ex : ex;
        aey = ey[37] ? -ey : ey;
    end

    // Pack the transaction for the back end
    always_comb
    begin
        job.is_box = (action == spc_pkg::ACT_BOX_BOX);
        job.bb_hit = bb_ok;
        job.bb_px  = 32'd0;
        job.bb_py  = 32'd0;
        if (bb_ok)
        begin
            if (adx > ady)
            begin
                job.bb_px = (dx > 38'sd0) ? 32'(-pen) : pen[31:0];
            end
            else
            begin
                job.bb_py = (dy > 38'sd0) ? 32'(-pen) : pen[31:0];
            end
        end
        job.cc     = is_cc;
        job.negate = (action == spc_pkg::ACT_CIRCLE_BOX);
        job.ax     = is_cc ? alx[36:0] : aex[36:0];
        job.ay     = is_cc ? aly[36:0] : aey[36:0];
        job.mlx    = alx[35:0];
        job.mly    = aly[35:0];
        job.sx     = lx[37];
        job.sy     = ly[37];
        job.rad    = is_cc ? rsum[31:0] : 32'(2 * cr);
    end

endmodule

// ===== rtl/spc_queue.sv =====
module spc_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  spc_pkg::spc_job_t  push_job,
    input  logic               pop,
    output logic               full,
    output logic               not_empty,
    output spc_pkg::spc_job_t  head
);

    localparam int AW = $clog2(spc_pkg::QUEUE_DEPTH);

    spc_pkg::spc_job_t mem [spc_pkg::QUEUE_DEPTH];
    logic [AW-1:0]     wr_reg, rd_reg;
    logic [AW:0]       cnt_reg;

    assign full      = (cnt_reg == (AW+1)'(spc_pkg::QUEUE_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head      = mem[rd_reg];

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= push_job;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/spc_back.sv =====
module spc_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_valid,
    input  spc_pkg::spc_job_t  job,
    output logic               pop,
    output logic               done,
    output logic               hit,
    output logic [31:0]        penetration_x,
    output logic [31:0]        penetration_y
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_SQ_A, ST_SQ_B, ST_RT1, ST_CHK1, ST_SQ_C, ST_SQ_D,
        ST_RT2, ST_CHK2, ST_MUL_X, ST_DIV_X, ST_MUL_Y, ST_DIV_Y, ST_OUT
    } state_t;

    state_t            state_reg;
    spc_pkg::spc_job_t ent_reg;
    logic [75:0]       acc_reg, mca_reg;
    logic [36:0]       mcb_reg;
    logic [6:0]        cnt_reg;
    logic [37:0]       root_reg;
    logic [39:0]       rem_reg;
    logic [31:0]       depth_reg;
    logic [38:0]       dvs_reg;
    logic [33:0]       qx_reg;
    logic              done_reg, hit_reg;
    logic [31:0]       px_reg, py_reg;

    logic [75:0] mul_acc;
    logic [41:0] rt_remn, rt_trial;
    logic        rt_ge;
    logic [39:0] dv_rn;
    logic        dv_ge;
    logic        mul_last, rt_last, dv_last;
    logic        hit_chk;
    logic        negx, negy;

    assign pop           = (state_reg == ST_IDLE) && job_valid;
    assign done          = done_reg;
    assign hit           = hit_reg;
    assign penetration_x = px_reg;
    assign penetration_y = py_reg;

    // Datapath steps of the serial units
    always_comb
    begin
        mul_acc  = mcb_reg[0] ? acc_reg + mca_reg : acc_reg;
        rt_remn  = {rem_reg, acc_reg[75:74]};
        rt_trial = {2'b00, root_reg, 2'b01};
        rt_ge    = (rt_remn >= rt_trial);
        dv_rn    = {rem_reg[38:0], acc_reg[75]};
        dv_ge    = (dv_rn >= {1'b0, dvs_reg});
        mul_last = (cnt_reg == 7'(spc_pkg::MUL_STEPS - 1));
        rt_last  = (cnt_reg == 7'(spc_pkg::RT_STEPS - 1));
        dv_last  = (cnt_reg == 7'(spc_pkg::DIV_STEPS - 1));
        hit_chk  = (root_reg < {6'b0, ent_reg.rad}) ||
                   ((root_reg == {6'b0, ent_reg.rad}) && (rem_reg == '0));
        negx     = ent_reg.sx ^ (ent_reg.cc | ent_reg.negate);
        negy     = ent_reg.sy ^ (ent_reg.cc | ent_reg.negate);
    end

    // Sequence one transaction: box-box results directly, circle pairs through squares, roots and projections
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (job_valid)
                    begin
                        ent_reg <= job;
                        if (job.is_box)
                        begin
                            done_reg <= 1'b1;
                            hit_reg  <= job.bb_hit;
                            px_reg   <= job.bb_px;
                            py_reg   <= job.bb_py;
                        end
                        else
                        begin
                            acc_reg   <= '0;
                            mca_reg   <= {39'b0, job.ax};
                            mcb_reg   <= job.ax;
                            cnt_reg   <= '0;
                            state_reg <= ST_SQ_A;
                        end
                    end
                end
                ST_SQ_A, ST_SQ_C, ST_MUL_X, ST_MUL_Y,
                ST_SQ_B, ST_SQ_D:
                begin
                    acc_reg <= mul_acc;
                    mca_reg <= {mca_reg[74:0], 1'b0};
                    mcb_reg <= {1'b0, mcb_reg[36:1]};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (mul_last)
                    begin
                        cnt_reg  <= '0;
                        rem_reg  <= '0;
                        root_reg <= '0;
                        unique case (state_reg)
                            ST_SQ_A:
                            begin
                                mca_reg   <= {39'b0, ent_reg.ay};
                                mcb_reg   <= ent_reg.ay;
                                state_reg <= ST_SQ_B;
                            end
                            ST_SQ_C:
                            begin
                                mca_reg   <= {40'b0, ent_reg.mly};
                                mcb_reg   <= {1'b0, ent_reg.mly};
                                state_reg <= ST_SQ_D;
                            end
                            ST_SQ_B:  state_reg <= ST_RT1;
                            ST_SQ_D:  state_reg <= ST_RT2;
                            ST_MUL_X: state_reg <= ST_DIV_X;
                            default:  state_reg <= ST_DIV_Y;
                        endcase
                    end
                end
                ST_RT1, ST_RT2:
                begin
                    acc_reg  <= {acc_reg[73:0], 2'b00};
                    rem_reg  <= rt_ge ? 40'(rt_remn - rt_trial) : rt_remn[39:0];
                    root_reg <= {root_reg[36:0], rt_ge};
                    cnt_reg  <= cnt_reg + 1'b1;
                    if (rt_last)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= (state_reg == ST_RT1) ? ST_CHK1 : ST_CHK2;
                    end
                end
                ST_CHK1:
                begin
                    depth_reg <= ent_reg.rad - root_reg[31:0];
                    acc_reg   <= '0;
                    if (!hit_chk)
                    begin
                        done_reg  <= 1'b1;
                        hit_reg   <= 1'b0;
                        px_reg    <= '0;
                        py_reg    <= '0;
                        state_reg <= ST_IDLE;
                    end
                    else if (ent_reg.cc && (root_reg == '0))
                    begin
                        done_reg  <= 1'b1;
                        hit_reg   <= 1'b1;
                        px_reg    <= '0;
                        py_reg    <= '0;
                        state_reg <= ST_IDLE;
                    end
                    else if (ent_reg.cc)
                    begin
                        dvs_reg   <= {1'b0, root_reg};
                        mca_reg   <= {40'b0, ent_reg.mlx};
                        mcb_reg   <= {5'b0, ent_reg.rad - root_reg[31:0]};
                        state_reg <= ST_MUL_X;
                    end
                    else
                    begin
                        mca_reg   <= {40'b0, ent_reg.mlx};
                        mcb_reg   <= {1'b0, ent_reg.mlx};
                        state_reg <= ST_SQ_C;
                    end
                end
                ST_CHK2:
                begin
                    acc_reg <= '0;
                    if (root_reg == '0)
                    begin
                        done_reg  <= 1'b1;
                        hit_reg   <= 1'b1;
                        px_reg    <= '0;
                        py_reg    <= '0;
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        dvs_reg   <= {root_reg, 1'b0};
                        mca_reg   <= {40'b0, ent_reg.mlx};
                        mcb_reg   <= {5'b0, depth_reg};
                        state_reg <= ST_MUL_X;
                    end
                end
                ST_DIV_X, ST_DIV_Y:
                begin
                    acc_reg <= {acc_reg[74:0], dv_ge};
                    rem_reg <= dv_ge ? (dv_rn - {1'b0, dvs_reg}) : dv_rn;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (dv_last)
                    begin
                        cnt_reg <= '0;
                        if (state_reg == ST_DIV_X)
                        begin
                            qx_reg    <= {acc_reg[32:0], dv_ge};
                            acc_reg   <= '0;
                            mca_reg   <= {40'b0, ent_reg.mly};
                            mcb_reg   <= {5'b0, depth_reg};
                            state_reg <= ST_MUL_Y;
                        end
                        else
                        begin
                            state_reg <= ST_OUT;
                        end
                    end
                end
                ST_OUT:
                begin
                    done_reg  <= 1'b1;
                    hit_reg   <= 1'b1;
                    px_reg    <= spc_pkg::spc_sat(qx_reg, negx);
                    py_reg    <= spc_pkg::spc_sat(acc_reg[33:0], negy);
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
            if (!(state_reg == ST_RT1 || state_reg == ST_RT2 || state_reg == ST_DIV_X ||
                  state_reg == ST_DIV_Y || state_reg == ST_SQ_A || state_reg == ST_SQ_B ||
                  state_reg == ST_SQ_C || state_reg == ST_SQ_D || state_reg == ST_MUL_X ||
                  state_reg == ST_MUL_Y))
            begin
                cnt_reg <= '0;
            end
        end
    end

endmodule

// ===== rtl/shape_pair_collision_2d.sv =====
// Collision test and push-out vector for one pair of 2D shapes (box or circle).
// Input channel: drive action and the shape fields and raise start; the
// transaction is taken at a rising edge where start is high and busy is low.
// Output channel: done is high for one cycle with hit, penetration_x and
// penetration_y; the result must be taken in that cycle, it is never held.
// A front stage classifies each pair and writes it into a four-entry queue;
// a back sequencer drains the queue in order, so results keep input order.
// With an idle back end, a box-box pair is first written into the queue and then
// its result is registered at the outputs; box-box pairs stream at one per cycle
// while no circle pair is in the back end. Circle pairs run a bit-serial
// multiplier, a two-bit-per-cycle square root and a bit-serial divider in the
// back end, which takes no new pair until it has finished the current one.
// A queued pair waits for earlier ones.
// busy is high while the queue is full.
// Reset clears the queue and the sequencer; no result is pending after it.
module shape_pair_collision_2d (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  action,
    input  logic [31:0] first_x,
    input  logic [31:0] first_y,
    input  logic [30:0] first_width,
    input  logic [30:0] first_height,
    input  logic [31:0] second_x,
    input  logic [31:0] second_y,
    input  logic [30:0] second_width,
    input  logic [30:0] second_height,
    output logic        done,
    output logic        hit,
    output logic [31:0] penetration_x,
    output logic [31:0] penetration_y
);

    spc_pkg::spc_job_t front_job, head_job;
    logic              q_full, q_valid, q_pop;

    // Classify the incoming pair
    spc_front u_front (
        .action        (action),
        .first_x       (first_x),
        .first_y       (first_y),
        .first_width   (first_width),
        .first_height  (first_height),
        .second_x      (second_x),
        .second_y      (second_y),
        .second_width  (second_width),
        .second_height (second_height),
        .job           (front_job)
    );

    // Hold classified transactions
    spc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (start && !q_full),
        .push_job  (front_job),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_valid),
        .head      (head_job)
    );

    // Compute and deliver results
    spc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .job_valid     (q_valid),
        .job           (head_job),
        .pop           (q_pop),
        .done          (done),
        .hit           (hit),
        .penetration_x (penetration_x),
        .penetration_y (penetration_y)
    );

    assign busy = q_full;

endmodule

// ===== bench/spc_checker.sv =====
module spc_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  action,
    input  logic [31:0] first_x,
    input  logic [31:0] first_y,
    input  logic [30:0] first_width,
    input  logic [30:0] first_height,
    input  logic [31:0] second_x,
    input  logic [31:0] second_y,
    input  logic [30:0] second_width,
    input  logic [30:0] second_height,
    input  logic        done,
    input  logic        hit,
    input  logic [31:0] penetration_x,
    input  logic [31:0] penetration_y,
    output int          pending,
    output int          fail_count
);

    typedef struct {
        logic        hit;
        logic [31:0] px;
        logic [31:0] py;
    } contact_t;

    contact_t contact_q[$];

    function automatic logic [63:0] mag(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic logic [127:0] sq_sum(input longint a, input longint b);
        logic [127:0] ma;
        logic [127:0] mb;
        ma = {64'd0, mag(a)};
        mb = {64'd0, mag(b)};
        return ma * ma + mb * mb;
    endfunction

    // Floor square root over a 41-bit search range; the hardware root is 38 bits wide
    function automatic logic [63:0] floor_sqrt(input logic [127:0] n);
        logic [63:0]  res;
        logic [63:0]  c;
        logic [127:0] cw;
        res = 64'd0;
        for (int b = 40; b >= 0; b--)
        begin
            c  = res | (64'd1 << b);
            cw = {64'd0, c};
            if (cw * cw <= n)
                res = c;
        end
        return res;
    endfunction

    // Scale depth by |comp| / len, truncate, then restore sign
    function automatic longint scale_comp(input logic [63:0] depth, input longint comp,
                                          input logic [63:0] len);
        logic [127:0] q;
        logic [63:0]  m;
        q = ({64'd0, depth} * {64'd0, mag(comp)}) / {64'd0, len};
        m = q[63:0];
        return (comp < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic logic [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647)
            v = 64'sd2147483647;
        if (v < -64'sd2147483648)
            v = -64'sd2147483648;
        return v[31:0];
    endfunction

    function automatic logic box_vs_circle(input longint bx, input longint by,
                                           input longint bw, input longint bh,
                                           input longint cx, input longint cy,
                                           input longint r,
                                           inout longint px, inout longint py);
        longint       lx;
        longint       ly;
        longint       kx;
        longint       ky;
        logic [127:0] dsq;
        logic [63:0]  r2;
        logic [63:0]  depth;
        logic [63:0]  len;
        lx = 2 * cx + 2 * r - 2 * bx - bw;
        ly = 2 * cy + 2 * r - 2 * by - bh;
        kx = (lx < -bw) ? -bw : ((lx > bw) ? bw : lx);
        ky = (ly < -bh) ? -bh : ((ly > bh) ? bh : ly);
        dsq = sq_sum(kx - lx, ky - ly);
        r2  = 2 * r;
        if (dsq > {64'd0, r2} * {64'd0, r2})
            return 1'b0;
        depth = r2 - floor_sqrt(dsq);
        len   = floor_sqrt(sq_sum(lx, ly));
        if (len != 0)
        begin
            px = scale_comp(depth, lx, 2 * len);
            py = scale_comp(depth, ly, 2 * len);
        end
        return 1'b1;
    endfunction

    function automatic contact_t predict_contact(input logic [1:0] act,
            input logic [31:0] ax, input logic [31:0] ay,
            input logic [30:0] aw, input logic [30:0] ah,
            input logic [31:0] bxr, input logic [31:0] byr,
            input logic [30:0] bwr, input logic [30:0] bhr);
        longint       x1, y1, w1, h1, x2, y2, w2, h2;
        longint       px, py, dx, dy, pen, lx, ly;
        logic [63:0]  rs, len, depth;
        logic [127:0] dsq;
        logic         h;
        contact_t     res;
        x1 = longint'($signed(ax));
        y1 = longint'($signed(ay));
        w1 = longint'({1'b0, aw});
        h1 = longint'({1'b0, ah});
        x2 = longint'($signed(bxr));
        y2 = longint'($signed(byr));
        w2 = longint'({1'b0, bwr});
        h2 = longint'({1'b0, bhr});
        px = 0;
        py = 0;
        h  = 1'b0;
        case (act)
            spc_pkg::ACT_BOX_BOX:
            begin
                if (x1 + w1 >= x2 && x2 + w2 >= x1 && y1 + h1 >= y2 && y2 + h2 >= y1)
                begin
                    h  = 1'b1;
                    dx = 2 * x1 + w1 - 2 * x2 - w2;
                    dy = 2 * y1 + h1 - 2 * y2 - h2;
                    // push along x only when strictly larger, ties go vertical
                    if (mag(dx) > mag(dy))
                    begin
                        pen = (w1 + w2 - longint'(mag(dx))) / 2;
                        px  = (dx > 0) ? -pen : pen;
                    end
                    else
                    begin
                        pen = (h1 + h2 - longint'(mag(dy))) / 2;
                        py  = (dy > 0) ? -pen : pen;
                    end
                end
            end
            spc_pkg::ACT_BOX_CIRCLE:
                h = box_vs_circle(x1, y1, w1, h1, x2, y2, w2, px, py);
            spc_pkg::ACT_CIRCLE_BOX:
            begin
                h  = box_vs_circle(x2, y2, w2, h2, x1, y1, w1, px, py);
                px = -px;
                py = -py;
            end
            default:
            begin
                lx  = (x1 + w1) - (x2 + w2);
                ly  = (y1 + w1) - (y2 + w2);
                rs  = w1 + w2;
                dsq = sq_sum(lx, ly);
                if (dsq <= {64'd0, rs} * {64'd0, rs})
                begin
                    h     = 1'b1;
                    len   = floor_sqrt(dsq);
                    depth = rs - len;
                    if (len != 0)
                    begin
                        px = -scale_comp(depth, lx, len);
                        py = -scale_comp(depth, ly, len);
                    end
                end
            end
        endcase
        if (!h)
        begin
            px = 0;
            py = 0;
        end
        res.hit = h;
        res.px  = clamp32(px);
        res.py  = clamp32(py);
        return res;
    endfunction

    // Predict on each accepted transaction, compare each result
    always @(posedge clk or negedge rst_n)
    begin : check_blk
        contact_t e;
        if (!rst_n)
        begin
            contact_q.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (start && !busy)
                contact_q.push_back(predict_contact(action, first_x, first_y, first_width,
                    first_height, second_x, second_y, second_width, second_height));
            if (done)
            begin
                if (contact_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result: hit=%0b px=%h py=%h",
                                 hit, penetration_x, penetration_y);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = contact_q.pop_front();
                    if (e.hit !== hit || e.px !== penetration_x || e.py !== penetration_y)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: exp hit=%0b px=%h py=%h, got hit=%0b px=%h py=%h",
                                     e.hit, e.px, e.py, hit, penetration_x, penetration_y);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= contact_q.size();
        end
    end

endmodule

// ===== bench/tb_shape_pair_collision_2d.sv =====
module tb_shape_pair_collision_2d;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  action;
    logic [31:0] first_x;
    logic [31:0] first_y;
    logic [30:0] first_width;
    logic [30:0] first_height;
    logic [31:0] second_x;
    logic [31:0] second_y;
    logic [30:0] second_width;
    logic [30:0] second_height;
    logic        done;
    logic        hit;
    logic [31:0] penetration_x;
    logic [31:0] penetration_y;
    int          pending;
    int          fail_count;

    localparam int RANDOM_PAIRS = 1130;

    shape_pair_collision_2d uut (.*);

    spc_checker chk (.*);

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Offer one pair and hold it until the block takes it
    task automatic send_pair(input logic [1:0] a, input logic [31:0] x1, input logic [31:0] y1,
                             input logic [30:0] w1, input logic [30:0] h1,
                             input logic [31:0] x2, input logic [31:0] y2,
                             input logic [30:0] w2, input logic [30:0] h2);
        action        <= a;
        first_x       <= x1;
        first_y       <= y1;
        first_width   <= w1;
        first_height  <= h1;
        second_x      <= x2;
        second_y      <= y2;
        second_width  <= w2;
        second_height <= h2;
        start         <= 1'b1;
        do
            @(negedge clk);
        while (busy);
        @(posedge clk);
    endtask

    task automatic hold_off(input int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // Random size: mostly small, sometimes any 31-bit value
    function automatic logic [30:0] rand_size(input int spread);
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return 31'($urandom());
        if (sel == 1)
            return 31'd0;
        return 31'($urandom_range(0, spread));
    endfunction

    // Build a pair that sits near contact, or pure noise
    task automatic send_random_pair();
        logic [1:0]  a;
        logic [31:0] x1, y1, x2, y2;
        logic [30:0] w1, h1, w2, h2;
        int          spread;
        int unsigned kind;
        kind   = $urandom_range(0, 19);
        a      = 2'($urandom_range(0, 3));
        spread = (kind < 10) ? 32'h0000_FFFF : 32'h00FF_FFFF;
        x1 = $urandom();
        y1 = $urandom();
        w1 = rand_size(spread);
        h1 = rand_size(spread);
        w2 = rand_size(spread);
        h2 = rand_size(spread);
        if (kind < 17)
        begin
            // keep the second shape within reach of the first
            x2 = x1 + $signed($urandom_range(0, 4 * spread)) - 2 * spread;
            y2 = y1 + $signed($urandom_range(0, 4 * spread)) - 2 * spread;
        end
        else
        begin
            x2 = $urandom();
            y2 = $urandom();
        end
        if (kind == 0)
        begin
            // same corner and sizes: coincident centres
            x2 = x1;
            y2 = y1;
            w2 = w1;
            h2 = h1;
        end
        send_pair(a, x1, y1, w1, h1, x2, y2, w2, h2);
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        start         <= 1'b0;
        action        <= spc_pkg::ACT_BOX_BOX;
        first_x       <= '0;
        first_y       <= '0;
        first_width   <= '0;
        first_height  <= '0;
        second_x      <= '0;
        second_y      <= '0;
        second_width  <= '0;
        second_height <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: boxes overlapping, tie, touching edge, miss, coincident, extremes
        send_pair(spc_pkg::ACT_BOX_BOX, 32'h0, 32'h0, 31'h20000, 31'h20000,
                  32'h18000, 32'h8000, 31'h20000, 31'h20000);
        send_pair(spc_pkg::ACT_BOX_BOX, 32'h0, 32'h0, 31'h20000, 31'h20000,
                  32'h10000, 32'h10000, 31'h20000, 31'h20000);
        send_pair(spc_pkg::ACT_BOX_BOX, 32'h0, 32'h0, 31'h10000, 31'h10000,
                  32'h10000, 32'h0, 31'h10000, 31'h10000);
        send_pair(spc_pkg::ACT_BOX_BOX, 32'h0, 32'h0, 31'h10000, 31'h10000,
                  32'h30000, 32'h0, 31'h10000, 31'h10000);
        send_pair(spc_pkg::ACT_BOX_BOX, 32'h5, 32'h5, 31'h40, 31'h40,
                  32'h5, 32'h5, 31'h40, 31'h40);
        send_pair(spc_pkg::ACT_BOX_BOX, 32'h8000_0000, 32'h8000_0000,
                  31'h7FFF_FFFF, 31'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        // Box then circle: hit, coincident centres, miss, saturating sizes
        send_pair(spc_pkg::ACT_BOX_CIRCLE, 32'h0, 32'h0, 31'h20000, 31'h20000,
                  32'h18000, 32'h0, 31'h10000, 31'h0);
        send_pair(spc_pkg::ACT_BOX_CIRCLE, 32'h0, 32'h0, 31'h20000, 31'h20000,
                  32'h0, 32'h0, 31'h10000, 31'h0);
        send_pair(spc_pkg::ACT_BOX_CIRCLE, 32'h0, 32'h0, 31'h10000, 31'h10000,
                  32'h50000, 32'h50000, 31'h10000, 31'h0);
        send_pair(spc_pkg::ACT_BOX_CIRCLE, 32'h8000_0000, 32'h8000_0000,
                  31'h7FFF_FFFF, 31'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        // Circle then box: hit, coincident, miss, extremes
        send_pair(spc_pkg::ACT_CIRCLE_BOX, 32'h0, 32'h8000, 31'h10000, 31'h0,
                  32'h0, 32'h0, 31'h20000, 31'h20000);
        send_pair(spc_pkg::ACT_CIRCLE_BOX, 32'h0, 32'h0, 31'h10000, 31'h0,
                  32'h0, 32'h0, 31'h20000, 31'h20000);
        send_pair(spc_pkg::ACT_CIRCLE_BOX, 32'h0, 32'h0, 31'h10000, 31'h0,
                  32'hFFF0_0000, 32'h0, 31'h10000, 31'h10000);
        send_pair(spc_pkg::ACT_CIRCLE_BOX, 32'h7FFF_FFFF, 32'h8000_0000,
                  31'h7FFF_FFFF, 31'h7FFF_FFFF,
                  32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h0);
        // Circle-circle: overlap, touching, coincident, miss, extremes, zero radii
        send_pair(spc_pkg::ACT_CIRC_CIRC, 32'h0, 32'h0, 31'h10000, 31'h0,
                  32'h8000, 32'h4000, 31'h10000, 31'h0);
        send_pair(spc_pkg::ACT_CIRC_CIRC, 32'h0, 32'h0, 31'h10000, 31'h0,
                  32'h20000, 32'h0, 31'h10000, 31'h0);
        send_pair(spc_pkg::ACT_CIRC_CIRC, 32'h1234, 32'h1234, 31'h10000, 31'h0,
                  32'h1234, 32'h1234, 31'h10000, 31'h0);
        send_pair(spc_pkg::ACT_CIRC_CIRC, 32'h0, 32'h0, 31'h10000, 31'h0,
                  32'h100000, 32'h100000, 31'h10000, 31'h0);
        send_pair(spc_pkg::ACT_CIRC_CIRC, 32'h8000_0000, 32'h8000_0000,
                  31'h7FFF_FFFF, 31'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        send_pair(spc_pkg::ACT_CIRC_CIRC, 32'h0, 32'h0, 31'h0, 31'h0,
                  32'h0, 32'h0, 31'h0, 31'h0);

        // Let the queue empty completely once
        drain_results();

        // Random pairs; no idling in the last stretch
        for (int i = 0; i < RANDOM_PAIRS; i++)
        begin
            if (i < RANDOM_PAIRS - 150 && $urandom_range(0, 3) == 0)
                hold_off($urandom_range(1, 12));
            if (i == RANDOM_PAIRS / 2)
                drain_results();
            send_random_pair();
        end
        start <= 1'b0;

        drain_results();
        repeat (600) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Guard against a hang
    initial
    begin
        #30000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
